FILE: hdl/feha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feha_pkg
// Shared widths, codes and helpers for the free extent heap allocator.
// ----------------------------------------------------------------------------
package feha_pkg;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 48;
    localparam int SIZE_W = 32;
    localparam int NEED_W = 33;
    localparam int STAT_W = 2;

    localparam int DEF_FREE_SLOTS     = 64;
    localparam int DEF_HEADER_BYTES   = 8;
    localparam int DEF_MIN_GROW_BYTES = 4096;

    localparam int ROUND_BYTES = 8;
    localparam int SMALL_TAIL  = 24;
    localparam int MIN_KEEP    = 8;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_GROW = 2'd1;
    localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

    typedef logic [4:0] t_cmd;

    localparam t_cmd C_NOP          = 5'd0;
    localparam t_cmd C_LOAD         = 5'd1;
    localparam t_cmd C_SET_FREE     = 5'd2;
    localparam t_cmd C_SET_ADD      = 5'd3;
    localparam t_cmd C_TAIL_FREE    = 5'd4;
    localparam t_cmd C_READ         = 5'd5;
    localparam t_cmd C_A_NEXT       = 5'd6;
    localparam t_cmd C_FIT          = 5'd7;
    localparam t_cmd C_D_READ       = 5'd8;
    localparam t_cmd C_D_WRITE      = 5'd9;
    localparam t_cmd C_D_END        = 5'd10;
    localparam t_cmd C_SET_TAIL_PUT = 5'd11;
    localparam t_cmd C_SET_REST_PUT = 5'd12;
    localparam t_cmd C_REST_TAIL    = 5'd13;
    localparam t_cmd C_CARVE        = 5'd14;
    localparam t_cmd C_MISS         = 5'd15;
    localparam t_cmd C_CLR_TAIL     = 5'd16;
    localparam t_cmd C_P_INIT       = 5'd17;
    localparam t_cmd C_P_PREV       = 5'd18;
    localparam t_cmd C_MERGE_PREV   = 5'd19;
    localparam t_cmd C_JOIN         = 5'd20;
    localparam t_cmd C_MERGE_NEXT   = 5'd21;
    localparam t_cmd C_LOST         = 5'd22;
    localparam t_cmd C_U_INIT       = 5'd23;
    localparam t_cmd C_U_READ       = 5'd24;
    localparam t_cmd C_U_WRITE      = 5'd25;
    localparam t_cmd C_INSERT       = 5'd26;
    localparam t_cmd C_FINISH       = 5'd27;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic addr_zero;
        logic tail_hit;
        logic idx_lt_cnt;
        logic d_more;
        logic fits;
        logic below;
        logic ps_zero;
        logic merge_prev;
        logic join_next;
        logic merge_next;
        logic full;
        logic tail_valid;
        logic tail_carve;
        logic rest_zero;
        logic rest_small;
        logic tail_small;
        logic tail_keep;
        logic u_more;
        logic out_full;
    } t_dp_sts;

    // saturate a 33-bit size to 32 bits
    function automatic logic [SIZE_W-1:0] clip32(input logic [NEED_W-1:0] v);
        clip32 = v[SIZE_W] ? {SIZE_W{1'b1}} : v[SIZE_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/feha_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feha_req_if
// Request channel: opcode, address and length with valid/ready.
// ----------------------------------------------------------------------------
interface feha_req_if import feha_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] length;

    modport source (output valid, output opcode, output address, output length, input ready);
    modport sink (input valid, input opcode, input address, input length, output ready);
endinterface
`default_nettype wire

FILE: hdl/feha_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feha_rsp_if
// Response channel: status, payload address and needed bytes with valid/ready.
// ----------------------------------------------------------------------------
interface feha_rsp_if import feha_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] payload_address;
    logic [SIZE_W-1:0] needed_bytes;

    modport source (output valid, output status, output payload_address,
                    output needed_bytes, input ready);
    modport sink (input valid, input status, input payload_address,
                  input needed_bytes, output ready);
endinterface
`default_nettype wire

FILE: hdl/feha_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feha_datapath
// Extent table memory, tail and operand registers, result register.
// ----------------------------------------------------------------------------
module feha_datapath import feha_pkg::*; #(
    parameter int FREE_SLOTS     = DEF_FREE_SLOTS,
    parameter int HEADER_BYTES   = DEF_HEADER_BYTES,
    parameter int MIN_GROW_BYTES = DEF_MIN_GROW_BYTES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic [SIZE_W-1:0] i_length,
    output t_dp_sts                o_sts,
    feha_rsp_if.source             o_rsp
);
    localparam int IW    = $clog2(FREE_SLOTS + 1);
    localparam int AW    = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
    localparam int ENT_W = ADDR_W + SIZE_W;

    localparam logic [ADDR_W-1:0] HDR_A   = ADDR_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] HDR_N   = NEED_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] RND_ADD = NEED_W'(ROUND_BYTES - 1);
    localparam logic [NEED_W-1:0] GROW_N  = NEED_W'(MIN_GROW_BYTES);
    localparam logic [IW-1:0]     CNT_MAX = IW'(FREE_SLOTS);

    logic [ENT_W-1:0] mem [FREE_SLOTS];

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [SIZE_W-1:0] r_len;
    logic [NEED_W-1:0] r_need, n_need;
    logic [ADDR_W-1:0] r_pb, n_pb;
    logic [SIZE_W-1:0] r_ps, n_ps;
    logic [IW-1:0]     r_idx, n_idx, r_cnt, n_cnt, r_sp, n_sp;
    logic [ENT_W-1:0]  r_rd;
    logic [ADDR_W-1:0] r_pv_base, n_pv_base;
    logic [SIZE_W-1:0] r_pv_size, n_pv_size;
    logic              r_have_prev, n_have_prev;
    logic [SIZE_W-1:0] r_mrg, n_mrg;
    logic [ADDR_W-1:0] r_rb, n_rb;
    logic [SIZE_W-1:0] r_rest, n_rest;
    logic [ADDR_W-1:0] r_tail_base, n_tail_base;
    logic [SIZE_W-1:0] r_tail_bytes, n_tail_bytes;
    logic              r_lost, n_lost;
    logic [STAT_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0] r_payload, n_payload;
    logic [SIZE_W-1:0] r_needed, n_needed;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_payload, n_out_payload;
    logic [SIZE_W-1:0] r_out_needed, n_out_needed;

    logic              w_en, rd_en;
    logic [AW-1:0]     w_addr, rd_addr;
    logic [ENT_W-1:0]  w_data;

    logic [ADDR_W-1:0] rd_base;
    logic [SIZE_W-1:0] rd_size;
    logic [IW-1:0]     idx_p1, idx_m1, sp_m1;
    logic [ADDR_W-1:0] blk;
    logic [NEED_W-1:0] full_len;
    logic [SIZE_W+1:0] tail_sum;
    logic [SIZE_W-1:0] mrg_calc, join_calc, next_calc;
    logic [NEED_W-1:0] rounded;

    assign rd_base   = r_rd[ENT_W-1:SIZE_W];
    assign rd_size   = r_rd[SIZE_W-1:0];
    assign idx_p1    = r_idx + 1'b1;
    assign idx_m1    = r_idx - 1'b1;
    assign sp_m1     = r_sp - 1'b1;
    assign blk       = r_addr - HDR_A;
    assign full_len  = {1'b0, r_len} + HDR_N;
    assign tail_sum  = {2'b00, r_tail_bytes} + {1'b0, full_len};
    assign mrg_calc  = clip32({1'b0, r_pv_size} + {1'b0, r_ps});
    assign join_calc = clip32({1'b0, r_mrg} + {1'b0, rd_size});
    assign next_calc = clip32({1'b0, r_ps} + {1'b0, rd_size});
    assign rounded   = ({1'b0, i_length} + RND_ADD) & ~RND_ADD;

    always_comb begin
        o_sts.op         = r_op;
        o_sts.addr_zero  = (r_addr == '0);
        o_sts.tail_hit   = (r_tail_bytes != '0)
                           && (({1'b0, blk} + (ADDR_W + 1)'(full_len)) == {1'b0, r_tail_base});
        o_sts.idx_lt_cnt = (r_idx < r_cnt);
        o_sts.d_more     = (({1'b0, r_idx} + 1'b1) < {1'b0, r_cnt});
        o_sts.fits       = ({1'b0, rd_size} >= r_need);
        o_sts.below      = (rd_base < r_pb);
        o_sts.ps_zero    = (r_ps == '0);
        o_sts.merge_prev = r_have_prev
                           && (({1'b0, r_pv_base} + (ADDR_W + 1)'(r_pv_size)) == {1'b0, r_pb});
        o_sts.join_next  = (({1'b0, r_pv_base} + (ADDR_W + 1)'(r_mrg)) == {1'b0, rd_base});
        o_sts.merge_next = (({1'b0, r_pb} + (ADDR_W + 1)'(r_ps)) == {1'b0, rd_base});
        o_sts.full       = (r_cnt >= CNT_MAX);
        o_sts.tail_valid = (r_tail_bytes != '0);
        o_sts.tail_carve = (r_tail_bytes != '0) && ({1'b0, r_tail_bytes} >= r_need);
        o_sts.rest_zero  = (r_rest == '0);
        o_sts.rest_small = (r_rest < SIZE_W'(SMALL_TAIL));
        o_sts.tail_small = (r_tail_bytes < SIZE_W'(SMALL_TAIL));
        o_sts.tail_keep  = (r_tail_bytes >= SIZE_W'(MIN_KEEP));
        o_sts.u_more     = (r_sp > r_idx);
        o_sts.out_full   = r_out_valid && !o_rsp.ready;
    end

    always_comb begin
        n_addr        = r_addr;
        n_need        = r_need;
        n_pb          = r_pb;
        n_ps          = r_ps;
        n_idx         = r_idx;
        n_cnt         = r_cnt;
        n_sp          = r_sp;
        n_pv_base     = r_pv_base;
        n_pv_size     = r_pv_size;
        n_have_prev   = r_have_prev;
        n_mrg         = r_mrg;
        n_rb          = r_rb;
        n_rest        = r_rest;
        n_tail_base   = r_tail_base;
        n_tail_bytes  = r_tail_bytes;
        n_lost        = r_lost;
        n_status      = r_status;
        n_payload     = r_payload;
        n_needed      = r_needed;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_payload = r_out_payload;
        n_out_needed  = r_out_needed;
        w_en          = 1'b0;
        w_addr        = r_idx[AW-1:0];
        w_data        = {r_pb, r_ps};
        rd_en         = 1'b0;
        rd_addr       = r_idx[AW-1:0];
        unique case (i_cmd)
            C_LOAD: begin
                n_addr    = i_address;
                n_need    = rounded + HDR_N;
                n_idx     = '0;
                n_lost    = 1'b0;
                n_status  = ST_DONE;
                n_payload = '0;
                n_needed  = '0;
            end
            C_SET_FREE: begin
                n_pb = blk;
                n_ps = clip32(full_len);
            end
            C_SET_ADD: begin
                n_pb = r_addr;
                n_ps = r_len;
            end
            C_TAIL_FREE: begin
                n_tail_base  = blk;
                n_tail_bytes = (|tail_sum[SIZE_W+1:SIZE_W]) ? {SIZE_W{1'b1}}
                                                             : tail_sum[SIZE_W-1:0];
            end
            C_READ: begin
                rd_en = 1'b1;
            end
            C_A_NEXT: begin
                n_idx = idx_p1;
            end
            C_FIT: begin
                n_payload = rd_base + HDR_A;
                n_rb      = rd_base + ADDR_W'(r_need);
                n_rest    = rd_size - r_need[SIZE_W-1:0];
            end
            C_D_READ: begin
                rd_en   = 1'b1;
                rd_addr = idx_p1[AW-1:0];
            end
            C_D_WRITE: begin
                w_en   = 1'b1;
                w_data = r_rd;
                n_idx  = idx_p1;
            end
            C_D_END: begin
                n_cnt = r_cnt - 1'b1;
            end
            C_SET_TAIL_PUT: begin
                n_pb         = r_tail_base;
                n_ps         = r_tail_bytes;
                n_tail_base  = '0;
                n_tail_bytes = '0;
            end
            C_SET_REST_PUT: begin
                n_pb = r_rb;
                n_ps = r_rest;
            end
            C_REST_TAIL: begin
                n_tail_base  = r_rb;
                n_tail_bytes = r_rest;
            end
            C_CARVE: begin
                n_payload    = r_tail_base + HDR_A;
                n_tail_base  = r_tail_base + ADDR_W'(r_need);
                n_tail_bytes = r_tail_bytes - r_need[SIZE_W-1:0];
            end
            C_MISS: begin
                n_status = ST_GROW;
                n_needed = clip32((r_need < GROW_N) ? GROW_N : r_need);
            end
            C_CLR_TAIL: begin
                n_tail_base  = '0;
                n_tail_bytes = '0;
            end
            C_P_INIT: begin
                n_idx       = '0;
                n_have_prev = 1'b0;
            end
            C_P_PREV: begin
                n_pv_base   = rd_base;
                n_pv_size   = rd_size;
                n_have_prev = 1'b1;
                n_idx       = idx_p1;
            end
            C_MERGE_PREV: begin
                w_en   = 1'b1;
                w_addr = idx_m1[AW-1:0];
                w_data = {r_pv_base, mrg_calc};
                n_mrg  = mrg_calc;
            end
            C_JOIN: begin
                w_en   = 1'b1;
                w_addr = idx_m1[AW-1:0];
                w_data = {r_pv_base, join_calc};
            end
            C_MERGE_NEXT: begin
                w_en   = 1'b1;
                w_data = {r_pb, next_calc};
            end
            C_LOST: begin
                n_lost = 1'b1;
            end
            C_U_INIT: begin
                n_sp = r_cnt;
            end
            C_U_READ: begin
                rd_en   = 1'b1;
                rd_addr = sp_m1[AW-1:0];
            end
            C_U_WRITE: begin
                w_en   = 1'b1;
                w_addr = r_sp[AW-1:0];
                w_data = r_rd;
                n_sp   = sp_m1;
            end
            C_INSERT: begin
                w_en  = 1'b1;
                n_cnt = r_cnt + 1'b1;
            end
            C_FINISH: begin
                n_out_valid   = 1'b1;
                n_out_status  = (r_status == ST_DONE && r_lost) ? ST_DROP : r_status;
                n_out_payload = r_payload;
                n_out_needed  = r_needed;
            end
            default: ;
        endcase
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_tail_base  <= '0;
            r_tail_bytes <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cnt        <= n_cnt;
            r_tail_base  <= n_tail_base;
            r_tail_bytes <= n_tail_bytes;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == C_LOAD) begin
            r_op  <= i_opcode;
            r_len <= i_length;
        end
        r_addr        <= n_addr;
        r_need        <= n_need;
        r_pb          <= n_pb;
        r_ps          <= n_ps;
        r_idx         <= n_idx;
        r_sp          <= n_sp;
        r_pv_base     <= n_pv_base;
        r_pv_size     <= n_pv_size;
        r_have_prev   <= n_have_prev;
        r_mrg         <= n_mrg;
        r_rb          <= n_rb;
        r_rest        <= n_rest;
        r_lost        <= n_lost;
        r_status      <= n_status;
        r_payload     <= n_payload;
        r_needed      <= n_needed;
        r_out_status  <= n_out_status;
        r_out_payload <= n_out_payload;
        r_out_needed  <= n_out_needed;
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out_status;
    assign o_rsp.payload_address = r_out_payload;
    assign o_rsp.needed_bytes    = r_out_needed;

endmodule
`default_nettype wire

FILE: hdl/feha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// feha_ctrl
// Sequencer for allocate, free and add-region: table scan, shifts, merges.
// ----------------------------------------------------------------------------
module feha_ctrl import feha_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_dp_sts i_sts,
    output t_cmd         o_cmd
);
    localparam int SW = 5;

    localparam logic [SW-1:0] S_IDLE    = 5'd0;
    localparam logic [SW-1:0] S_DISP    = 5'd1;
    localparam logic [SW-1:0] S_A_RD    = 5'd2;
    localparam logic [SW-1:0] S_A_EV    = 5'd3;
    localparam logic [SW-1:0] S_D_RD    = 5'd4;
    localparam logic [SW-1:0] S_D_WR    = 5'd5;
    localparam logic [SW-1:0] S_A_PTAIL = 5'd6;
    localparam logic [SW-1:0] S_A_REST  = 5'd7;
    localparam logic [SW-1:0] S_A_TAIL  = 5'd8;
    localparam logic [SW-1:0] S_A_CARVE = 5'd9;
    localparam logic [SW-1:0] S_P_START = 5'd10;
    localparam logic [SW-1:0] S_P_RD    = 5'd11;
    localparam logic [SW-1:0] S_P_EV    = 5'd12;
    localparam logic [SW-1:0] S_P_DEC   = 5'd13;
    localparam logic [SW-1:0] S_P_M2    = 5'd14;
    localparam logic [SW-1:0] S_U_RD    = 5'd15;
    localparam logic [SW-1:0] S_U_WR    = 5'd16;
    localparam logic [SW-1:0] S_DONE    = 5'd17;

    logic [SW-1:0] r_state, n_state;
    logic [SW-1:0] r_ret, n_ret;
    logic          r_dput, n_dput;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_dput  = r_dput;
        o_cmd   = C_NOP;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd   = C_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_ret = S_DONE;
                case (i_sts.op)
                    OP_ALLOC: n_state = S_A_RD;
                    OP_FREE: begin
                        if (i_sts.addr_zero) begin
                            n_state = S_DONE;
                        end else if (i_sts.tail_hit) begin
                            o_cmd   = C_TAIL_FREE;
                            n_state = S_DONE;
                        end else begin
                            o_cmd   = C_SET_FREE;
                            n_state = S_P_START;
                        end
                    end
                    OP_ADD: begin
                        o_cmd   = C_SET_ADD;
                        n_state = S_P_START;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_A_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd   = C_READ;
                    n_state = S_A_EV;
                end else begin
                    n_state = S_A_TAIL;
                end
            end
            S_A_EV: begin
                if (i_sts.fits) begin
                    o_cmd   = C_FIT;
                    n_dput  = 1'b0;
                    n_state = S_D_RD;
                end else begin
                    o_cmd   = C_A_NEXT;
                    n_state = S_A_RD;
                end
            end
            S_D_RD: begin
                if (i_sts.d_more) begin
                    o_cmd   = C_D_READ;
                    n_state = S_D_WR;
                end else begin
                    o_cmd   = C_D_END;
                    n_state = r_dput ? r_ret : S_A_PTAIL;
                end
            end
            S_D_WR: begin
                o_cmd   = C_D_WRITE;
                n_state = S_D_RD;
            end
            S_A_PTAIL: begin
                // the old tail goes back into the table before the remainder
                if (i_sts.tail_valid) begin
                    o_cmd   = C_SET_TAIL_PUT;
                    n_ret   = S_A_REST;
                    n_state = S_P_START;
                end else begin
                    n_state = S_A_REST;
                end
            end
            S_A_REST: begin
                if (i_sts.rest_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.rest_small) begin
                    o_cmd   = C_SET_REST_PUT;
                    n_ret   = S_DONE;
                    n_state = S_P_START;
                end else begin
                    o_cmd   = C_REST_TAIL;
                    n_state = S_DONE;
                end
            end
            S_A_TAIL: begin
                if (i_sts.tail_carve) begin
                    o_cmd   = C_CARVE;
                    n_state = S_A_CARVE;
                end else begin
                    o_cmd   = C_MISS;
                    n_state = S_DONE;
                end
            end
            S_A_CARVE: begin
                if (i_sts.tail_small && i_sts.tail_keep) begin
                    o_cmd   = C_SET_TAIL_PUT;
                    n_ret   = S_DONE;
                    n_state = S_P_START;
                end else if (i_sts.tail_small) begin
                    o_cmd   = C_CLR_TAIL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_P_START: begin
                if (i_sts.ps_zero) begin
                    n_state = r_ret;
                end else begin
                    o_cmd   = C_P_INIT;
                    n_state = S_P_RD;
                end
            end
            S_P_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    o_cmd   = C_READ;
                    n_state = S_P_EV;
                end else begin
                    n_state = S_P_DEC;
                end
            end
            S_P_EV: begin
                if (i_sts.below) begin
                    o_cmd   = C_P_PREV;
                    n_state = S_P_RD;
                end else begin
                    n_state = S_P_DEC;
                end
            end
            S_P_DEC: begin
                if (i_sts.merge_prev) begin
                    o_cmd   = C_MERGE_PREV;
                    n_state = S_P_M2;
                end else if (i_sts.idx_lt_cnt && i_sts.merge_next) begin
                    o_cmd   = C_MERGE_NEXT;
                    n_state = r_ret;
                end else if (i_sts.full) begin
                    o_cmd   = C_LOST;
                    n_state = r_ret;
                end else begin
                    o_cmd   = C_U_INIT;
                    n_state = S_U_RD;
                end
            end
            S_P_M2: begin
                // merged extent now touches the next one: fold it in and drop it
                if (i_sts.idx_lt_cnt && i_sts.join_next) begin
                    o_cmd   = C_JOIN;
                    n_dput  = 1'b1;
                    n_state = S_D_RD;
                end else begin
                    n_state = r_ret;
                end
            end
            S_U_RD: begin
                if (i_sts.u_more) begin
                    o_cmd   = C_U_READ;
                    n_state = S_U_WR;
                end else begin
                    o_cmd   = C_INSERT;
                    n_state = r_ret;
                end
            end
            S_U_WR: begin
                o_cmd   = C_U_WRITE;
                n_state = S_U_RD;
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd   = C_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_DONE;
            r_dput  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_dput  <= n_dput;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/free_extent_heap_allocator.sv
`default_nettype none
// From accept, an item goes through dispatch, then any table scan, removal and up to two
//   insertions, then the result register. One item at a time: the next one is taken
//   only once the result is posted, and a result not yet taken holds the sequencer.
//   Each table entry visited or moved is read first through the registered read port,
//   then evaluated or written.
// Reset: synchronous, active low; empties the table and the tail at once.
// ----------------------------------------------------------------------------
// free_extent_heap_allocator
// First-fit free extent allocator with coalescing and a bump tail region.
// ----------------------------------------------------------------------------
module free_extent_heap_allocator import feha_pkg::*; #(
    parameter int FREE_SLOTS     = DEF_FREE_SLOTS,
    parameter int HEADER_BYTES   = DEF_HEADER_BYTES,
    parameter int MIN_GROW_BYTES = DEF_MIN_GROW_BYTES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    feha_req_if.sink   i_req,
    feha_rsp_if.source o_rsp
);
    t_cmd    w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    assign i_req.ready = w_ready;

    feha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (w_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    feha_datapath #(
        .FREE_SLOTS     (FREE_SLOTS),
        .HEADER_BYTES   (HEADER_BYTES),
        .MIN_GROW_BYTES (MIN_GROW_BYTES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_opcode  (i_req.opcode),
        .i_address (i_req.address),
        .i_length  (i_req.length),
        .o_sts     (w_sts),
        .o_rsp     (o_rsp)
    );

`ifndef SYNTHESIS
    a_fit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_FIT) |-> w_sts.fits)
        else $error("allocation took an extent that is too small");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_INSERT) |-> !w_sts.full)
        else $error("insertion into a full table");

    a_finish_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_FINISH) |-> !w_sts.out_full)
        else $error("result written over one not yet taken");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd == C_LOAD) |=> !i_req.ready)
        else $error("second item accepted while one is in progress");
`endif

endmodule
`default_nettype wire
